// ----- hdl/gic_pkg.sv -----
// Shared types and constants for the grouped integer 2-D convolution unit.
// Used by the controller, the datapath, the top level and the checker.
package gic_pkg;

	// Store and window limits; the port and register widths are sized for these.
	localparam int MAX_CHANNELS = 16;
	localparam int MAX_SIDE     = 64;
	localparam int MAX_KERNEL   = 7;

	localparam logic [1:0] CMD_WEIGHT  = 2'd0;
	localparam logic [1:0] CMD_BIAS    = 2'd1;
	localparam logic [1:0] CMD_PIXEL   = 2'd2;
	localparam logic [1:0] CMD_COMPUTE = 2'd3;

	localparam logic [2:0] REG_IN_CH   = 3'd0;
	localparam logic [2:0] REG_OUT_CH  = 3'd1;
	localparam logic [2:0] REG_GROUPS  = 3'd2;
	localparam logic [2:0] REG_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_WIDTH   = 3'd4;
	localparam logic [2:0] REG_FILTER  = 3'd5;
	localparam logic [2:0] REG_STRIDE  = 3'd6;
	localparam logic [2:0] REG_PADBIAS = 3'd7;

	localparam int CFG_W   = 12;
	localparam int CFG_IDX_W = 3;
	// Signed width of a window row or column position.
	localparam int POS_W   = 11;

	localparam logic [1:0] DIV_OPG = 2'd0;
	localparam logic [1:0] DIV_IPG = 2'd1;
	localparam logic [1:0] DIV_GRP = 2'd2;

	typedef struct packed {
		logic       wr;
		logic       start;
		logic       div_load;
		logic [1:0] div_sel;
		logic       setup_en;
		logic [1:0] setup_step;
		logic       tap_en;
		logic       finish;
	} gic_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic tap_last;
		logic oc_bad;
		logic out_busy;
	} gic_sts_t;

endpackage

// ----- hdl/gic_ctrl.sv -----
// Sequencing state machine of the convolution unit.
// Drives gic_dp through gic_pkg command and status structs.
module gic_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        command,
	input  gic_pkg::gic_sts_t sts,
	output logic              in_stall,
	output gic_pkg::gic_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIVLD = 3'd2;
	localparam logic [2:0] ST_DIVWT = 3'd3;
	localparam logic [2:0] ST_SETUP = 3'd4;
	localparam logic [2:0] ST_RUN   = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] div_idx_q, div_idx_d;
	logic [1:0] step_q, step_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		div_idx_d = div_idx_q;
		step_d = step_q;
		cmd = '0;
		cmd.div_sel = div_idx_q;
		cmd.setup_step = step_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (command == gic_pkg::CMD_COMPUTE) begin
						cmd.start = 1'b1;
						state_d = ST_CHECK;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_CHECK: begin
				div_idx_d = gic_pkg::DIV_OPG;
				state_d = sts.oc_bad ? ST_FIN : ST_DIVLD;
			end
			ST_DIVLD: begin
				cmd.div_load = 1'b1;
				state_d = ST_DIVWT;
			end
			ST_DIVWT: begin
				if (!sts.div_busy) begin
					if (div_idx_q == gic_pkg::DIV_GRP) begin
						step_d = 2'd0;
						state_d = ST_SETUP;
					end else begin
						div_idx_d = div_idx_q + 2'd1;
						state_d = ST_DIVLD;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup_en = 1'b1;
				step_d = step_q + 2'd1;
				if (step_q == 2'd2) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.tap_en = 1'b1;
				if (sts.tap_last) begin
					step_d = 2'd0;
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// The drain states let the last product reach the accumulator.
				step_d = step_q + 2'd1;
				if (step_q == 2'd1) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_idx_q <= 2'd0;
			step_q <= 2'd0;
		end else begin
			state_q <= state_d;
			div_idx_q <= div_idx_d;
			step_q <= step_d;
		end
	end

endmodule

// ----- hdl/gic_dp.sv -----
// Datapath of the convolution unit: configuration registers, the three stores,
// a subtractive divider, window address counters and the multiply-accumulate.
module gic_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gic_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gic_pkg::CFG_W-1:0]     cfg_data,
	input  logic [1:0]                    command,
	input  logic [15:0]                   address,
	input  logic signed [31:0]            value,
	input  logic [3:0]                    out_channel,
	input  logic [5:0]                    out_row,
	input  logic [5:0]                    out_col,
	input  logic                          out_stall,
	input  gic_pkg::gic_cmd_t             cmd,
	output gic_pkg::gic_sts_t             sts,
	output logic                          out_valid,
	output logic signed [31:0]            result
);

	localparam int WDEPTH = gic_pkg::MAX_CHANNELS * gic_pkg::MAX_CHANNELS *
		gic_pkg::MAX_KERNEL * gic_pkg::MAX_KERNEL;
	localparam int PDEPTH = gic_pkg::MAX_CHANNELS * gic_pkg::MAX_SIDE * gic_pkg::MAX_SIDE;
	localparam int WA_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int PA_W = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
	localparam int BA_W = (gic_pkg::MAX_CHANNELS > 1) ? $clog2(gic_pkg::MAX_CHANNELS) : 1;
	localparam int PW = gic_pkg::POS_W;

	logic [31:0] wmem [WDEPTH];
	logic [31:0] pmem [PDEPTH];
	logic [31:0] bmem [gic_pkg::MAX_CHANNELS];

	logic [4:0]  in_ch_q, out_ch_q, groups_q;
	logic [6:0]  height_q, width_q;
	logic [5:0]  filter_q;
	logic [11:0] stride_q;
	logic [6:0]  padbias_q;

	logic [4:0] ic_n, oc_n, min_n, g_n;
	logic [6:0] h_n, w_n;
	logic [2:0] kh, kw, sh, sw, dh, dw, pt, pl;
	logic       bias_on;

	logic [3:0]  oc_q;
	logic [5:0]  orow_q, ocol_q;
	logic [4:0]  div_rem_q, div_den_q, div_quo_q;
	logic [1:0]  div_sel_q;
	logic        div_busy_q;
	logic [4:0]  opg_q, ipg_q, grp_q, grp_c;

	logic [WA_W-1:0] ta_q, wi_q;
	logic [9:0]      base_q;
	logic [PA_W-1:0] hw_q, chan_q, dhw_q, r0w_q, rw_q, xi;
	logic signed [PW-1:0] r0_q, q0_q, r_q, q_q;
	logic [4:0] c_q;
	logic [2:0] fh_q, fw_q;
	logic       in_range;

	logic [31:0] wrd_s1, prd_s1, bias_rd_q;
	logic        valid_s1, valid_s2;
	logic [31:0] prod_s2, acc_q;
	logic        out_valid_q;
	logic [31:0] result_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q <= 5'd1;
			out_ch_q <= 5'd1;
			groups_q <= 5'd1;
			height_q <= 7'd1;
			width_q <= 7'd1;
			filter_q <= 6'd9;
			stride_q <= 12'd585;
			padbias_q <= 7'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				gic_pkg::REG_IN_CH:   in_ch_q <= cfg_data[4:0];
				gic_pkg::REG_OUT_CH:  out_ch_q <= cfg_data[4:0];
				gic_pkg::REG_GROUPS:  groups_q <= cfg_data[4:0];
				gic_pkg::REG_HEIGHT:  height_q <= cfg_data[6:0];
				gic_pkg::REG_WIDTH:   width_q <= cfg_data[6:0];
				gic_pkg::REG_FILTER:  filter_q <= cfg_data[5:0];
				gic_pkg::REG_STRIDE:  stride_q <= cfg_data[11:0];
				gic_pkg::REG_PADBIAS: padbias_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Saturated working values.
	always_comb begin
		ic_n = (in_ch_q == 5'd0) ? 5'd1 :
			(32'(in_ch_q) > gic_pkg::MAX_CHANNELS) ? 5'(gic_pkg::MAX_CHANNELS) : in_ch_q;
		oc_n = (out_ch_q == 5'd0) ? 5'd1 :
			(32'(out_ch_q) > gic_pkg::MAX_CHANNELS) ? 5'(gic_pkg::MAX_CHANNELS) : out_ch_q;
		min_n = (ic_n < oc_n) ? ic_n : oc_n;
		g_n = (groups_q == 5'd0) ? 5'd1 : (groups_q > min_n) ? min_n : groups_q;
		h_n = (height_q == 7'd0) ? 7'd1 :
			(32'(height_q) > gic_pkg::MAX_SIDE) ? 7'(gic_pkg::MAX_SIDE) : height_q;
		w_n = (width_q == 7'd0) ? 7'd1 :
			(32'(width_q) > gic_pkg::MAX_SIDE) ? 7'(gic_pkg::MAX_SIDE) : width_q;
		kh = (filter_q[2:0] == 3'd0) ? 3'd1 :
			(32'(filter_q[2:0]) > gic_pkg::MAX_KERNEL) ? 3'(gic_pkg::MAX_KERNEL) :
			filter_q[2:0];
		kw = (filter_q[5:3] == 3'd0) ? 3'd1 :
			(32'(filter_q[5:3]) > gic_pkg::MAX_KERNEL) ? 3'(gic_pkg::MAX_KERNEL) :
			filter_q[5:3];
		sh = stride_q[2:0];
		sw = stride_q[5:3];
		dh = stride_q[8:6];
		dw = stride_q[11:9];
		pt = padbias_q[2:0];
		pl = padbias_q[5:3];
		bias_on = padbias_q[6];
		grp_c = (grp_q > g_n - 5'd1) ? g_n - 5'd1 : grp_q;
	end

	// Stores: written on accepted write requests, read with registered data.
	always_ff @(posedge clk) begin
		if (cmd.wr && command == gic_pkg::CMD_WEIGHT && 32'(address) < WDEPTH) begin
			wmem[WA_W'(address)] <= value;
		end
		wrd_s1 <= wmem[wi_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && command == gic_pkg::CMD_PIXEL && 32'(address) < PDEPTH) begin
			pmem[PA_W'(address)] <= value;
		end
		prd_s1 <= pmem[xi];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && command == gic_pkg::CMD_BIAS &&
				32'(address) < gic_pkg::MAX_CHANNELS) begin
			bmem[BA_W'(address)] <= value;
		end
		bias_rd_q <= bmem[BA_W'(oc_q)];
	end

	// Subtractive divider for the per-group counts and the group index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
		end else if (cmd.div_load) begin
			div_busy_q <= 1'b1;
		end else if (div_busy_q && div_rem_q < div_den_q) begin
			div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			oc_q <= out_channel;
			orow_q <= out_row;
			ocol_q <= out_col;
		end
		if (cmd.div_load) begin
			div_sel_q <= cmd.div_sel;
			div_quo_q <= 5'd0;
			case (cmd.div_sel)
				gic_pkg::DIV_OPG: begin
					div_rem_q <= oc_n;
					div_den_q <= g_n;
				end
				gic_pkg::DIV_IPG: begin
					div_rem_q <= ic_n;
					div_den_q <= g_n;
				end
				default: begin
					div_rem_q <= 5'(oc_q);
					div_den_q <= opg_q;
				end
			endcase
		end else if (div_busy_q) begin
			if (div_rem_q >= div_den_q) begin
				div_rem_q <= div_rem_q - div_den_q;
				div_quo_q <= div_quo_q + 5'd1;
			end else begin
				case (div_sel_q)
					gic_pkg::DIV_OPG: opg_q <= div_quo_q;
					gic_pkg::DIV_IPG: ipg_q <= div_quo_q;
					default:          grp_q <= div_quo_q;
				endcase
			end
		end
	end

	// Window setup and tap counters. Weight taps are contiguous, so the
	// weight address simply counts; pixel addresses are built by additions.
	assign in_range = !r_q[PW-1] && (r_q < $signed(PW'(h_n)))
		&& !q_q[PW-1] && (q_q < $signed(PW'(w_n)));
	assign xi = chan_q + rw_q + PA_W'(q_q);

	always_ff @(posedge clk) begin
		if (cmd.setup_en) begin
			case (cmd.setup_step)
				2'd0: begin
					ta_q <= WA_W'(WA_W'(oc_q) * WA_W'(ipg_q));
					base_q <= 10'(grp_c) * 10'(ipg_q);
					hw_q <= PA_W'(PA_W'(h_n) * PA_W'(w_n));
				end
				2'd1: begin
					ta_q <= WA_W'(ta_q * WA_W'(kh));
					chan_q <= PA_W'(PA_W'(base_q) * hw_q);
					r0_q <= $signed(PW'(PW'(orow_q) * PW'(sh))) - $signed(PW'(pt));
					q0_q <= $signed(PW'(PW'(ocol_q) * PW'(sw))) - $signed(PW'(pl));
					dhw_q <= PA_W'(PA_W'(dh) * PA_W'(w_n));
				end
				default: begin
					wi_q <= WA_W'(ta_q * WA_W'(kw));
					r0w_q <= PA_W'(PA_W'(r0_q) * PA_W'(w_n));
					rw_q <= PA_W'(PA_W'(r0_q) * PA_W'(w_n));
					r_q <= r0_q;
					q_q <= q0_q;
					c_q <= 5'd0;
					fh_q <= 3'd0;
					fw_q <= 3'd0;
				end
			endcase
		end else if (cmd.tap_en) begin
			wi_q <= wi_q + WA_W'(1);
			if (fw_q == kw - 3'd1) begin
				fw_q <= 3'd0;
				q_q <= q0_q;
				if (fh_q == kh - 3'd1) begin
					fh_q <= 3'd0;
					r_q <= r0_q;
					rw_q <= r0w_q;
					c_q <= c_q + 5'd1;
					chan_q <= chan_q + hw_q;
				end else begin
					fh_q <= fh_q + 3'd1;
					r_q <= r_q + $signed(PW'(dh));
					rw_q <= rw_q + dhw_q;
				end
			end else begin
				fw_q <= fw_q + 3'd1;
				q_q <= q_q + $signed(PW'(dw));
			end
		end
	end

	// Multiply-accumulate pipeline: read, multiply, add.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.tap_en && in_range;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= wrd_s1 * prd_s1;
		if (cmd.start) begin
			acc_q <= 32'd0;
		end else if (valid_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (sts.oc_bad) begin
				result_q <= 32'd0;
			end else begin
				result_q <= acc_q + (bias_on ? bias_rd_q : 32'd0);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result = result_q;

	assign sts.div_busy = div_busy_q;
	assign sts.tap_last = (c_q == ipg_q - 5'd1) && (fh_q == kh - 3'd1) && (fw_q == kw - 3'd1);
	assign sts.oc_bad = (5'(oc_q) >= oc_n);
	assign sts.out_busy = out_valid_q && out_stall;

endmodule

// ----- hdl/grouped_int_conv2d_unit.sv -----
// Grouped, dilated integer 2-D convolution unit, one output point per request.
// Write requests are taken while idle and do not stall the input. A compute request
// holds the input until its result is registered, paced by the subtractive divider
// and the single multiply-accumulate that handles one tap per cycle; an output
// channel past the last goes straight to a zero result. A stalled result holds it longer.
// Reset sets control and configuration to their defaults; the stores are not cleared.
module grouped_int_conv2d_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gic_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gic_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    command,
	input  logic [15:0]                   address,
	input  logic signed [31:0]            value,
	input  logic [3:0]                    out_channel,
	input  logic [5:0]                    out_row,
	input  logic [5:0]                    out_col,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [31:0]            result
);

	gic_pkg::gic_cmd_t cmd;
	gic_pkg::gic_sts_t sts;

	gic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	gic_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.command     (command),
		.address     (address),
		.value       (value),
		.out_channel (out_channel),
		.out_row     (out_row),
		.out_col     (out_col),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.result      (result)
	);

endmodule

// ----- hdl/gic_chk.sv -----
// Port-level checker for the convolution unit, bound to the top level.
// Depends on gic_pkg for the request command codes.
module gic_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  command,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result))
		else $error("result changed while stalled");

	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command == gic_pkg::CMD_COMPUTE |=> in_stall)
		else $error("compute request did not make the unit busy");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command != gic_pkg::CMD_COMPUTE |=> !in_stall)
		else $error("store write left the unit busy");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a compute in progress");

endmodule

bind grouped_int_conv2d_unit gic_chk u_gic_chk (.*);
